@@ hdl/ibdo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ibdo_pkg;

    // store sizing
    localparam int MAX_BOXES = 64;
    localparam int HW_LIMIT  = 64;
    localparam int CAPACITY  = (MAX_BOXES < HW_LIMIT) ? MAX_BOXES : HW_LIMIT;
    localparam int IDX_W     = $clog2(HW_LIMIT);
    localparam int COUNT_W   = IDX_W + 1;
    localparam int COORD_W   = 32;
    localparam int TAG_W     = 16;

    // one stored box, as held in the box memory
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    // outcome of one box against the new box
    typedef struct packed {
        logic behind;
        logic ahead;
    } t_cls;

    // list codes, also used as list slots
    localparam logic [1:0] CLS_BACK  = 2'd0;
    localparam logic [1:0] CLS_FRONT = 2'd1;
    localparam logic [1:0] CLS_PEND  = 2'd2;

endpackage

`default_nettype wire

@@ hdl/iso_box_depth_order.sv @@
// insert: an insert walks every stored box, classifying and linking each one, then
//   links the back list, the new box, the front list and the pending list in order
// throughput: one item at a time; the walk through the link memory sets the rate
// on the last item the draw results go out one at a time, each held until taken
// reset: synchronous active low; clears the order, box count and overflow flag
`timescale 1ns / 1ps
`default_nettype none

module iso_box_depth_order
    import ibdo_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_min_x,
    input  wire logic signed [COORD_W-1:0] i_min_y,
    input  wire logic signed [COORD_W-1:0] i_min_z,
    input  wire logic signed [COORD_W-1:0] i_max_x,
    input  wire logic signed [COORD_W-1:0] i_max_y,
    input  wire logic signed [COORD_W-1:0] i_max_z,
    input  wire logic [TAG_W-1:0]          i_item_tag,
    input  wire logic                      i_last_in,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [TAG_W-1:0]               o_tag_out,
    output logic [IDX_W-1:0]               o_draw_index,
    output logic                           o_last_out,
    output logic                           o_overflow
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAIT  = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_JOIN  = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_FIN1  = 4'd5;
    localparam logic [3:0] S_FIN2  = 4'd6;
    localparam logic [3:0] S_FIN3  = 4'd7;
    localparam logic [3:0] S_ERD   = 4'd8;
    localparam logic [3:0] S_EOUT  = 4'd9;
    localparam logic [3:0] S_EWAIT = 4'd10;

    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

    logic [3:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_k, n_k;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_s, n_s;
    logic               r_drop, n_drop;
    logic               r_last, n_last;
    logic [1:0]         r_cls, n_cls;
    logic [IDX_W-1:0]   r_lhead [3];
    logic [IDX_W-1:0]   n_lhead [3];
    logic [IDX_W-1:0]   r_ltail [3];
    logic [IDX_W-1:0]   n_ltail [3];
    logic [2:0]         r_lne, n_lne;
    logic               r_ovalid, n_ovalid;
    logic [TAG_W-1:0]   r_otag;
    logic [IDX_W-1:0]   r_oidx;
    logic               r_olast, r_oovf;
    logic               n_oload;
    t_box               r_nb;

    logic               in_acc;
    logic               box_we;
    t_box               box_wd;
    t_box               box_rd;
    logic               link_we;
    logic [IDX_W-1:0]   link_wa;
    logic [IDX_W-1:0]   link_wd;
    logic [IDX_W-1:0]   link_rd;
    logic [IDX_W-1:0]   new_idx;
    logic               is_final;
    t_cls               cls;

    assign o_ready      = (r_state == S_IDLE);
    assign in_acc       = i_valid && o_ready;
    assign new_idx      = r_count[IDX_W-1:0];
    assign is_final     = (r_k == r_count - COUNT_W'(1));
    assign o_valid      = r_ovalid;
    assign o_tag_out    = r_otag;
    assign o_draw_index = r_oidx;
    assign o_last_out   = r_olast;
    assign o_overflow   = r_oovf;

    // new box goes straight into the store unless the store is full
    assign box_we = in_acc && (r_count < CAP);
    always_comb begin
        box_wd.tag   = i_item_tag;
        box_wd.min_x = i_min_x;
        box_wd.min_y = i_min_y;
        box_wd.min_z = i_min_z;
        box_wd.max_x = i_max_x;
        box_wd.max_y = i_max_y;
        box_wd.max_z = i_max_z;
    end

    ibdo_ram #(
        .WIDTH (BOX_W),
        .DEPTH (HW_LIMIT)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (box_we),
        .i_waddr (new_idx),
        .i_wdata (box_wd),
        .i_raddr (r_cur),
        .o_rdata (box_rd)
    );

    ibdo_ram #(
        .WIDTH (IDX_W),
        .DEPTH (HW_LIMIT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (r_cur),
        .o_rdata (link_rd)
    );

    // shared compare unit: stored box under the walk against the new box
    ibdo_cmp u_cmp (
        .i_old (box_rd),
        .i_new (r_nb),
        .o_cls (cls)
    );

    // new box copy for the walk
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_nb <= box_wd;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_head   = r_head;
        n_cur    = r_cur;
        n_s      = r_s;
        n_drop   = r_drop;
        n_last   = r_last;
        n_cls    = r_cls;
        n_lhead  = r_lhead;
        n_ltail  = r_ltail;
        n_lne    = r_lne;
        n_ovalid = r_ovalid;
        n_oload  = 1'b0;
        link_we  = 1'b0;
        link_wa  = r_ltail[r_cls];
        link_wd  = r_s;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_last_in;
                    n_lne  = 3'b000;
                    n_k    = '0;
                    n_cur  = r_head;
                    if (r_count < CAP) begin
                        n_state = (r_count == '0) ? S_FIN1 : S_WAIT;
                    end else begin
                        n_drop  = 1'b1;
                        n_state = i_last_in ? S_ERD : S_IDLE;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_CMP;
            end
            // classify one stored box and step to its successor
            S_CMP: begin
                n_s   = r_cur;
                n_cur = link_rd;
                if (cls.behind == cls.ahead) begin
                    n_cls = CLS_PEND;
                end else if (cls.behind) begin
                    n_cls = CLS_BACK;
                end else begin
                    n_cls = CLS_FRONT;
                end
                n_state = ((n_cls != CLS_PEND) && r_lne[CLS_PEND]) ? S_JOIN : S_PUSH;
            end
            // pending list moves onto the chosen list
            S_JOIN: begin
                if (r_lne[r_cls]) begin
                    link_we = 1'b1;
                    link_wd = r_lhead[CLS_PEND];
                end else begin
                    n_lhead[r_cls] = r_lhead[CLS_PEND];
                end
                n_ltail[r_cls] = r_ltail[CLS_PEND];
                n_lne[r_cls]   = 1'b1;
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                if (r_lne[r_cls]) begin
                    link_we = 1'b1;
                end else begin
                    n_lhead[r_cls] = r_s;
                end
                n_ltail[r_cls] = r_s;
                n_lne[r_cls]   = 1'b1;
                if (r_cls != CLS_PEND) begin
                    n_lne[CLS_PEND] = 1'b0;
                end
                n_k     = r_k + COUNT_W'(1);
                n_state = is_final ? S_FIN1 : S_CMP;
            end
            // back list, then the new box
            S_FIN1: begin
                if (r_lne[CLS_BACK]) begin
                    link_we = 1'b1;
                    link_wa = r_ltail[CLS_BACK];
                    link_wd = new_idx;
                    n_head  = r_lhead[CLS_BACK];
                end else begin
                    n_head = new_idx;
                end
                n_state = S_FIN2;
            end
            // new box, then front list or pending list
            S_FIN2: begin
                link_we = r_lne[CLS_FRONT] || r_lne[CLS_PEND];
                link_wa = new_idx;
                link_wd = r_lne[CLS_FRONT] ? r_lhead[CLS_FRONT] : r_lhead[CLS_PEND];
                n_state = S_FIN3;
            end
            // front list, then pending list
            S_FIN3: begin
                link_we = r_lne[CLS_FRONT] && r_lne[CLS_PEND];
                link_wa = r_ltail[CLS_FRONT];
                link_wd = r_lhead[CLS_PEND];
                n_count = r_count + COUNT_W'(1);
                n_cur   = r_head;
                n_k     = '0;
                n_state = r_last ? S_ERD : S_IDLE;
            end
            S_ERD: begin
                n_state = S_EOUT;
            end
            S_EOUT: begin
                n_oload  = 1'b1;
                n_ovalid = 1'b1;
                n_cur    = link_rd;
                n_state  = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_count = '0;
                        n_head  = '0;
                        n_cur   = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + COUNT_W'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_head   <= '0;
            r_cur    <= '0;
            r_drop   <= 1'b0;
            r_last   <= 1'b0;
            r_lne    <= 3'b000;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_head   <= n_head;
            r_cur    <= n_cur;
            r_drop   <= n_drop;
            r_last   <= n_last;
            r_lne    <= n_lne;
            r_ovalid <= n_ovalid;
        end
    end

    // walk payload and output transaction registers
    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_cls   <= n_cls;
        r_lhead <= n_lhead;
        r_ltail <= n_ltail;
        if (n_oload) begin
            r_otag  <= box_rd.tag;
            r_oidx  <= r_k[IDX_W-1:0];
            r_olast <= is_final;
            r_oovf  <= is_final && r_drop;
        end
    end

    // checks
    a_ready_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while a result transaction is pending");

    a_count_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("box count above capacity");

    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |-> (o_draw_index == IDX_W'(r_count - COUNT_W'(1))))
        else $error("final draw index does not match box count");

    a_ovf_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> o_last_out)
        else $error("overflow flagged on a non-final result");

endmodule

`default_nettype wire

@@ hdl/ibdo_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ibdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/ibdo_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ibdo_cmp
    import ibdo_pkg::*;
(
    input  wire t_box i_old,
    input  wire t_box i_new,
    output t_cls      o_cls
);

    // stored box behind: its max strictly below the new min on some axis
    assign o_cls.behind = (i_old.max_x < i_new.min_x) ||
                          (i_old.max_y < i_new.min_y) ||
                          (i_old.max_z < i_new.min_z);

    // stored box in front: new max strictly below its min on some axis
    assign o_cls.ahead  = (i_new.max_x < i_old.min_x) ||
                          (i_new.max_y < i_old.min_y) ||
                          (i_new.max_z < i_old.min_z);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ibdo_pkg::*;

    // one draw-order transaction as seen on the output
    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic             fin;
        logic             ovf;
    } t_draw;

    // scoreboard: keeps its own copy of the draw order and the expected draws
    class depth_order_board;
        t_box  boxes [CAPACITY];
        int    draw_order [$];
        bit    dropped;
        t_draw pending_draws [$];
        int    errors;
        int    draws_seen;

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) $display("ERROR %0t: %s", $time, msg);
        endfunction

        // true when box a lies fully on the low side of box b on some axis
        function bit clear_below(t_box a, t_box b);
            return ($signed(a.max_x) < $signed(b.min_x)) ||
                   ($signed(a.max_y) < $signed(b.min_y)) ||
                   ($signed(a.max_z) < $signed(b.min_z));
        endfunction

        // an accepted box: insert it if there is room, and on the last one release the order
        function void note_box(t_box b, bit last);
            int back_list [$];
            int front_list [$];
            int pend_list [$];
            int slot;
            bit behind;
            bit ahead;
            if (draw_order.size() < CAPACITY) begin
                slot = draw_order.size();
                boxes[slot] = b;
                foreach (draw_order[k]) begin
                    behind = clear_below(boxes[draw_order[k]], b);
                    ahead  = clear_below(b, boxes[draw_order[k]]);
                    if (behind == ahead) begin
                        pend_list.push_back(draw_order[k]);
                    end else if (behind) begin
                        back_list = {back_list, pend_list, draw_order[k]};
                        pend_list.delete();
                    end else begin
                        front_list = {front_list, pend_list, draw_order[k]};
                        pend_list.delete();
                    end
                end
                draw_order = {back_list, slot, front_list, pend_list};
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                foreach (draw_order[k]) begin
                    t_draw d;
                    d.tag = boxes[draw_order[k]].tag;
                    d.idx = k[IDX_W-1:0];
                    d.fin = (k == draw_order.size() - 1);
                    d.ovf = d.fin & dropped;
                    pending_draws.push_back(d);
                end
                draw_order.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_draw(t_draw got);
            t_draw exp_d;
            draws_seen++;
            if (pending_draws.size() == 0) begin
                flag_error($sformatf("unexpected draw tag=%h idx=%0d", got.tag, got.idx));
                return;
            end
            exp_d = pending_draws.pop_front();
            if (got.tag !== exp_d.tag)
                flag_error($sformatf("tag exp %h got %h", exp_d.tag, got.tag));
            if (got.idx !== exp_d.idx)
                flag_error($sformatf("index exp %0d got %0d", exp_d.idx, got.idx));
            if (got.fin !== exp_d.fin)
                flag_error($sformatf("last exp %b got %b", exp_d.fin, got.fin));
            if (got.ovf !== exp_d.ovf)
                flag_error($sformatf("overflow exp %b got %b", exp_d.ovf, got.ovf));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [COORD_W-1:0] i_min_x = '0, i_min_y = '0, i_min_z = '0;
    logic signed [COORD_W-1:0] i_max_x = '0, i_max_y = '0, i_max_z = '0;
    logic [TAG_W-1:0] i_item_tag = '0;
    logic i_last_in = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [TAG_W-1:0] o_tag_out;
    logic [IDX_W-1:0] o_draw_index;
    logic o_last_out;
    logic o_overflow;

    depth_order_board board = new();
    int hold_left = 0;
    int burst_left = 0;
    int boxes_sent = 0;
    int sets_sent = 0;

    always #2 i_clk = ~i_clk;

    iso_box_depth_order i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_min_x      (i_min_x),
        .i_min_y      (i_min_y),
        .i_min_z      (i_min_z),
        .i_max_x      (i_max_x),
        .i_max_y      (i_max_y),
        .i_max_z      (i_max_z),
        .i_item_tag   (i_item_tag),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tag_out    (o_tag_out),
        .o_draw_index (o_draw_index),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow)
    );

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_draw('{o_tag_out, o_draw_index, o_last_out, o_overflow});
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        logic [31:0] stall_pat;
        int pat_age;
        stall_pat = '1;
        pat_age = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                if (pat_age == 0) begin
                    pat_age = $urandom_range(50, 300);
                    case ($urandom_range(0, 2))
                        0: stall_pat = '1;
                        1: stall_pat = $urandom();
                        default: stall_pat = $urandom() | $urandom();
                    endcase
                end
                pat_age--;
                stall_pat = {stall_pat[30:0], stall_pat[31]};
                i_ready = stall_pat[0];
            end
        end
    end

    // one box through the input handshake, sender idling in bursts
    task automatic send_box(t_box b, bit last);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        i_valid    = 1'b1;
        i_min_x    = b.min_x;
        i_min_y    = b.min_y;
        i_min_z    = b.min_z;
        i_max_x    = b.max_x;
        i_max_y    = b.max_y;
        i_max_z    = b.max_z;
        i_item_tag = b.tag;
        i_last_in  = last;
        do @(posedge i_clk); while (!o_ready);
        board.note_box(b, last);
        boxes_sent++;
        if (last) sets_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $signed($urandom_range(0, 16)) - 8 <<< 16;
            1: return $urandom();
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic t_box rand_box(int mode);
        t_box b;
        logic [31:0] a, c;
        a = pick_coord(mode); c = pick_coord(mode);
        // mostly well formed, a few inverted
        if (($signed(a) > $signed(c)) ^ ($urandom_range(0, 9) == 0)) begin
            b.min_x = c; b.max_x = a;
        end else begin
            b.min_x = a; b.max_x = c;
        end
        a = pick_coord(mode); c = pick_coord(mode);
        if ($signed(a) > $signed(c)) begin b.min_y = c; b.max_y = a; end
        else begin b.min_y = a; b.max_y = c; end
        a = pick_coord(mode); c = pick_coord(mode);
        if ($signed(a) > $signed(c)) begin b.min_z = c; b.max_z = a; end
        else begin b.min_z = a; b.max_z = c; end
        b.tag = TAG_W'($urandom());
        return b;
    endfunction

    function automatic t_box make_box(int x0, int y0, int z0, int x1, int y1, int z1,
                                      int tag);
        t_box b;
        b.min_x = x0; b.min_y = y0; b.min_z = z0;
        b.max_x = x1; b.max_y = y1; b.max_z = z1;
        b.tag = TAG_W'(tag);
        return b;
    endfunction

    task automatic send_set(int n, int mode_hi);
        for (int k = 0; k < n; k++)
            send_box(rand_box($urandom_range(0, mode_hi)), k == n - 1);
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single box set
        send_box(make_box(0, 0, 0, 1, 1, 1, 16'h0001), 1'b1);
        // extremes of every field, an inverted box, and equal faces (no strict order)
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000), 1'b0);
        send_box(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff), 1'b0);
        send_box(make_box(0, 0, 0, 0, 0, 0, 16'h5a5a), 1'b1);
        // clearly behind, clearly in front, overlapping (pending), then linking boxes
        send_box(make_box(10, 10, 10, 20, 20, 20, 16'h0010), 1'b0);
        send_box(make_box(0, 0, 0, 5, 5, 5, 16'h0011), 1'b0);
        send_box(make_box(30, 30, 30, 40, 40, 40, 16'h0012), 1'b0);
        send_box(make_box(15, 15, 15, 35, 35, 35, 16'h0013), 1'b0);
        send_box(make_box(0, 30, 0, 5, 40, 5, 16'h0014), 1'b0);
        send_box(make_box(20, 0, 0, 30, 5, 5, 16'h0015), 1'b0);
        send_box(make_box(-50, -50, -50, -40, -40, -40, 16'h0016), 1'b1);
        // touching faces are neither behind nor in front
        send_box(make_box(0, 0, 0, 10, 10, 10, 16'h0020), 1'b0);
        send_box(make_box(10, 10, 10, 20, 20, 20, 16'h0021), 1'b1);

        // full store, then overflow with dropped boxes
        send_set(CAPACITY, 1);
        send_set(CAPACITY + 3, 0);

        // random sets, small ones mostly; one long receiver hold-off
        while (boxes_sent < 260) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            if (sets_sent == 8) begin
                send_set(n - 1 + 1, 2);
                hold_left = 400;
                send_set(8, 0);
            end else begin
                send_set(n, $urandom_range(0, 3) == 0 ? 2 : 0);
            end
        end
        i_valid = 1'b0;

        wait (board.pending_draws.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d boxes in %0d sets sent, %0d draw transactions checked",
                 boxes_sent, sets_sent, board.draws_seen);
        $display("covered full store, overflow, inverted and extreme boxes, long output stall");
        if (board.errors == 0 && board.pending_draws.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d draws left waiting", board.errors,
                     board.pending_draws.size());
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ibdo_pkg.sv
hdl/ibdo_ram.sv
hdl/ibdo_cmp.sv
hdl/iso_box_depth_order.sv
tb/tb_top.sv
